// ===== sv/channel_peak_direction_finder_defines.svh =====
// Assertion macros shared by the channel peak direction finder modules
`ifndef CHANNEL_PEAK_DIRECTION_FINDER_DEFINES_SVH
`define CHANNEL_PEAK_DIRECTION_FINDER_DEFINES_SVH

// Same-cycle implication, checked on clk, disabled in reset
`define CPDF_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, disabled in reset
`define CPDF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cpdf_pkg.sv =====
// Shared constants and types of the channel peak direction finder
`default_nettype none

package cpdf_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int SAMPLES_DEF  = 16;

    localparam int SAMPLE_W    = 12;
    localparam int CHAN_W      = 4;
    localparam int DEG_W       = 9;
    localparam int SAMPLE_MAX  = 4095;
    localparam int FULL_CIRCLE = 360;
    localparam int ADDR_CHANS  = 2 ** CHAN_W;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [CHAN_W-1:0]   channel;
        logic                hit;
        logic                last;
    } word_t;

endpackage

`default_nettype wire

// ===== sv/cpdf_front.sv =====
// Input stage: accept sample words, classify channel range, feed the queue
`default_nettype none

module cpdf_front #(
    parameter int CHANNELS = cpdf_pkg::CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [cpdf_pkg::SAMPLE_W-1:0] sample_value,
    input  logic [cpdf_pkg::CHAN_W-1:0]   channel,
    input  logic                          frame_last,
    output logic                          push_valid,
    output cpdf_pkg::word_t               push_word,
    input  logic                          queue_full
);

    logic            word_valid_reg;
    logic            word_valid_next;
    cpdf_pkg::word_t word_reg;
    logic            accept;
    logic            hit;

    assign sample_stall = word_valid_reg & queue_full;
    assign accept       = sample_valid & ~sample_stall;
    assign hit          = (int'(channel) < CHANNELS);
    assign push_valid   = word_valid_reg;
    assign push_word    = word_reg;

    always_comb
    begin
        if (accept)
        begin
            word_valid_next = 1'b1;
        end
        else if (!queue_full)
        begin
            word_valid_next = 1'b0;
        end
        else
        begin
            word_valid_next = word_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
        end
        else
        begin
            word_valid_reg <= word_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.value   <= sample_value;
            word_reg.channel <= channel;
            word_reg.hit     <= hit;
            word_reg.last    <= frame_last;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cpdf_queue.sv =====
// Short word queue between the input stage and the accumulate/scan engine
`default_nettype none
`include "channel_peak_direction_finder_defines.svh"

module cpdf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  cpdf_pkg::word_t push_word,
    output logic            full,
    input  logic            pop,
    output cpdf_pkg::word_t pop_word,
    output logic            empty
);

    localparam int DEPTH = cpdf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpdf_pkg::word_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push_ok;
    logic              pop_ok;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign push_ok  = push_valid & ~full;
    assign pop_ok   = pop & ~empty;
    assign pop_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    `CPDF_ASSERT_IMP(a_no_pop_empty, pop, !empty, "queue popped while empty")
    `CPDF_ASSERT_NEXT(a_count_tracks, push_ok && !pop_ok, !empty, "push lost in queue")

endmodule

`default_nettype wire

// ===== sv/cpdf_back.sv =====
// Accumulate engine, end-of-frame peak scan and result register
`default_nettype none
`include "channel_peak_direction_finder_defines.svh"

module cpdf_back #(
    parameter int CHANNELS = cpdf_pkg::CHANNELS_DEF,
    parameter int SAMPLES  = cpdf_pkg::SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          queue_empty,
    input  cpdf_pkg::word_t               pop_word,
    output logic                          pop,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [cpdf_pkg::DEG_W-1:0]    direction_deg,
    output logic [cpdf_pkg::CHAN_W-1:0]   peak_channel,
    output logic [cpdf_pkg::SAMPLE_W-1:0] peak_average
);

    localparam int NCH       = (CHANNELS < cpdf_pkg::ADDR_CHANS) ? CHANNELS
                                                                 : cpdf_pkg::ADDR_CHANS;
    localparam int IDX_W     = $clog2(NCH);
    localparam int ACC_LIMIT = SAMPLES * cpdf_pkg::SAMPLE_MAX;
    localparam int ACC_W     = $clog2(ACC_LIMIT + 1);
    localparam int LOG_S     = $clog2(SAMPLES);
    localparam int SH        = ACC_W + LOG_S;
    localparam int RECIP_W   = ACC_W + 1;
    localparam int PROD_W    = ACC_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
    localparam int DEG_STEP  = cpdf_pkg::FULL_CIRCLE / CHANNELS;
    localparam int HEAD_W    = cpdf_pkg::CHAN_W + cpdf_pkg::DEG_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_MUL  = 5'b00100,
        S_CMP  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [ACC_W-1:0]              acc_reg [NCH];
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic [ACC_W-1:0]              acc_rd_reg;
    logic [cpdf_pkg::SAMPLE_W-1:0] avg_reg;
    logic [cpdf_pkg::SAMPLE_W-1:0] best_avg_reg;
    logic [cpdf_pkg::SAMPLE_W-1:0] best_avg_next;
    logic [IDX_W-1:0]              best_idx_reg;
    logic [IDX_W-1:0]              best_idx_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [cpdf_pkg::DEG_W-1:0]    deg_reg;
    logic [cpdf_pkg::CHAN_W-1:0]   peak_ch_reg;
    logic [cpdf_pkg::SAMPLE_W-1:0] peak_avg_reg;
    logic [IDX_W-1:0]              wr_idx;
    logic [ACC_W:0]                sum;
    logic [ACC_W-1:0]              sum_sat;
    logic [PROD_W-1:0]             prod;
    logic [HEAD_W-1:0]             heading;
    logic                          acc_write;
    logic                          load;

    assign pop        = (state_reg == S_IDLE) && !queue_empty;
    assign acc_write  = pop && pop_word.hit;
    assign wr_idx     = pop_word.hit ? pop_word.channel[IDX_W-1:0] : '0;
    assign sum        = {1'b0, acc_reg[wr_idx]} + (ACC_W + 1)'(pop_word.value);
    assign sum_sat    = (sum > (ACC_W + 1)'(ACC_LIMIT)) ? ACC_W'(ACC_LIMIT) : sum[ACC_W-1:0];
    assign prod       = PROD_W'(acc_rd_reg) * PROD_W'(RECIP_W'(RECIP));
    assign heading    = HEAD_W'(best_idx_reg) * HEAD_W'(DEG_STEP);
    assign load       = (state_reg == S_EMIT) && (!out_valid_reg || !result_stall);

    assign result_valid  = out_valid_reg;
    assign direction_deg = deg_reg;
    assign peak_channel  = peak_ch_reg;
    assign peak_average  = peak_avg_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        best_avg_next = best_avg_reg;
        best_idx_next = best_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop && pop_word.last)
                begin
                    idx_next      = '0;
                    best_avg_next = '0;
                    best_idx_next = '0;
                    state_next    = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (avg_reg > best_avg_reg)
                begin
                    best_avg_next = avg_reg;
                    best_idx_next = idx_reg;
                end
                if (idx_reg == IDX_W'(NCH - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCH; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                for (int i = 0; i < NCH; i++)
                begin
                    acc_reg[i] <= '0;
                end
            end
            else if (acc_write)
            begin
                acc_reg[wr_idx] <= sum_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_avg_reg <= best_avg_next;
        best_idx_reg <= best_idx_next;
        if (state_reg == S_RD)
        begin
            acc_rd_reg <= acc_reg[idx_reg];
        end
        if (state_reg == S_MUL)
        begin
            avg_reg <= prod[SH +: cpdf_pkg::SAMPLE_W];
        end
        if (load)
        begin
            deg_reg      <= heading[cpdf_pkg::DEG_W-1:0];
            peak_ch_reg  <= cpdf_pkg::CHAN_W'(best_idx_reg);
            peak_avg_reg <= best_avg_reg;
        end
    end

    `CPDF_ASSERT_IMP(a_pop_idle, pop, state_reg == S_IDLE, "word taken during frame scan")
    `CPDF_ASSERT_IMP(a_no_overwrite, load, !out_valid_reg || !result_stall,
                     "pending result overwritten")
    `CPDF_ASSERT_NEXT(a_clear_after_emit, load, acc_reg[0] == '0,
                      "accumulators not cleared after result")

endmodule

`default_nettype wire

// ===== sv/channel_peak_direction_finder.sv =====
// Top level of the channel peak direction finder
//
//  word    | direction | fields                                   | handshake
//  --------+-----------+------------------------------------------+--------------------------
//  sample  | in        | sample_value, channel, frame_last        | sample_valid/sample_stall
//  result  | out       | direction_deg, peak_channel, peak_average | result_valid/result_stall
//
// A sample word passes the input register and the queue and is added into its channel
// accumulator in the cycle it leaves the queue, one word per cycle while the scan is idle.
// A frame_last word then starts a scan (read, reciprocal multiply, compare) over each of
// the min(CHANNELS, 16) channel accumulators in turn, then a load of the result register.
// Words are still taken during the scan until the queue and the input register are full.
// Reset clears accumulators, queue and result_valid; a stalled result holds up the next.
`default_nettype none

module channel_peak_direction_finder #(
    parameter int CHANNELS = cpdf_pkg::CHANNELS_DEF,
    parameter int SAMPLES  = cpdf_pkg::SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [cpdf_pkg::SAMPLE_W-1:0] sample_value,
    input  logic [cpdf_pkg::CHAN_W-1:0]   channel,
    input  logic                          frame_last,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [cpdf_pkg::DEG_W-1:0]    direction_deg,
    output logic [cpdf_pkg::CHAN_W-1:0]   peak_channel,
    output logic [cpdf_pkg::SAMPLE_W-1:0] peak_average
);

    logic            push_valid;
    cpdf_pkg::word_t push_word;
    logic            queue_full;
    logic            queue_empty;
    logic            pop;
    cpdf_pkg::word_t pop_word;

    cpdf_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_value (sample_value),
        .channel      (channel),
        .frame_last   (frame_last),
        .push_valid   (push_valid),
        .push_word    (push_word),
        .queue_full   (queue_full)
    );

    cpdf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_word  (push_word),
        .full       (queue_full),
        .pop        (pop),
        .pop_word   (pop_word),
        .empty      (queue_empty)
    );

    cpdf_back #(
        .CHANNELS (CHANNELS),
        .SAMPLES  (SAMPLES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (queue_empty),
        .pop_word      (pop_word),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .direction_deg (direction_deg),
        .peak_channel  (peak_channel),
        .peak_average  (peak_average)
    );

endmodule

`default_nettype wire
